### rtl/sac_pkg.sv
// shared constants and types for the set-associative cache tag lookup
package sac_pkg;

   localparam int ADDR_W      = 64;
   localparam int SETS_DEF    = 64;
   localparam int WAYS_DEF    = 4;
   localparam int WAY_IDX_W   = 4;
   localparam int WAY_USED_W  = 2;
   localparam int OFFSET_W    = 4;
   localparam int HIT_CYC_W   = 8;
   localparam int PENALTY_W   = 16;
   localparam int LATENCY_W   = 17;
   localparam int COUNT_W     = 32;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY         = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_CYCLES     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY_CYCLES = 4'd3;

   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   localparam logic [OFFSET_W-1:0]  OFFSET_BITS_RST    = 4'd6;
   localparam logic                 POLICY_RST         = POLICY_LRU;
   localparam logic [HIT_CYC_W-1:0] HIT_CYCLES_RST     = 8'd1;
   localparam logic [PENALTY_W-1:0] PENALTY_CYCLES_RST = 16'd100;

   typedef struct packed {
      logic                 hit;
      logic [WAY_IDX_W-1:0] way;
   } lookup_status_type;

endpackage

### rtl/sac_ram.sv
// single-port-write, single-port-read synchronous memory with registered read data
module sac_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/sac_way_logic.sv
// tag compare across the ways of a set and update of valid bits, tags and age order
module sac_way_logic #(
   parameter int WAYS  = 4,
   parameter int TAG_W = 58,
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic [TAG_W-1:0]         tag,
   input  logic [WAYS*TAG_W-1:0]    line_tags,
   input  logic [WAYS-1:0]          line_valid,
   input  logic [WAYS*WAY_W-1:0]    way_order,
   input  logic                     policy,
   output sac_pkg::lookup_status_type status,
   output logic [WAYS*TAG_W-1:0]    new_tags,
   output logic [WAYS-1:0]          new_valid,
   output logic [WAYS*WAY_W-1:0]    new_order
);
   import sac_pkg::*;

   logic                   hit;
   logic [WAY_W-1:0]       way;
   logic [WAY_W-1:0]       pos;
   logic                   move;
   logic [WAYS*WAY_W-1:0]  order_shift;

   always_comb begin
      hit = 1'b0;
      way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (line_valid[w] && (line_tags[w*TAG_W +: TAG_W] == tag)) begin
            hit = 1'b1;
            way = WAY_W'(w);
         end
      end
      if (!hit) begin
         way = way_order[0 +: WAY_W];
      end

      pos = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (way_order[i*WAY_W +: WAY_W] == way) begin
            pos = WAY_W'(i);
         end
      end

      move = !hit || (policy == POLICY_LRU);
      order_shift = way_order >> WAY_W;
      new_order = way_order;
      for (int i = 0; i < WAYS; i++) begin
         if (move && (WAY_W'(i) >= pos)) begin
            if (i == WAYS - 1) begin
               new_order[i*WAY_W +: WAY_W] = way;
            end else begin
               new_order[i*WAY_W +: WAY_W] = order_shift[i*WAY_W +: WAY_W];
            end
         end
      end

      new_valid = line_valid;
      new_tags  = line_tags;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && (way == WAY_W'(w))) begin
            new_valid[w] = 1'b1;
            new_tags[w*TAG_W +: TAG_W] = tag;
         end
      end

      status.hit = hit;
      status.way = WAY_IDX_W'(way);
   end

endmodule

### rtl/set_assoc_cache_tag_lookup_top.sv
// top level of the set-associative cache tag lookup with lru or fifo replacement
// Each address passes through ST_IDLE and ST_LOOKUP: in ST_IDLE the transfer reads
// the tag row and the valid/order row of its set from two synchronous memories, and
// in ST_LOOKUP all ways are compared, the valid/order row is written back (the tag
// row only on a miss) and the result register is loaded. ST_LOOKUP waits while the
// previous result is stalled, and no new address is taken until it is done. After
// reset a clearing pass writes every set's valid bits to zero and its
// age order to ways 0 to WAYS-1; no address is taken during that pass, while
// register writes are taken at any time. SETS must be a power of two.
module set_assoc_cache_tag_lookup_top #(
   parameter int SETS = sac_pkg::SETS_DEF,
   parameter int WAYS = sac_pkg::WAYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sac_pkg::ADDR_W-1:0]          req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [sac_pkg::WAY_USED_W-1:0]      rsp_way_used,
   output logic [sac_pkg::LATENCY_W-1:0]       rsp_latency,
   output logic [sac_pkg::COUNT_W-1:0]         rsp_access_total,
   output logic [sac_pkg::COUNT_W-1:0]         rsp_hit_total,
   output logic [sac_pkg::COUNT_W-1:0]         rsp_miss_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sac_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sac_pkg::*;

   localparam int SET_BITS = $clog2(SETS);
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_W    = ADDR_W - SET_BITS;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ORDER_W  = WAYS * WAY_W;
   localparam int META_W   = ORDER_W + WAYS;
   localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);
   localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [ORDER_W-1:0] init_order();
      logic [ORDER_W-1:0] o;
      o = '0;
      for (int w = 0; w < WAYS; w++) begin
         o[w*WAY_W +: WAY_W] = WAY_W'(w);
      end
      init_order = o;
   endfunction

   // configuration registers
   logic [OFFSET_W-1:0]  offset_bits_ff;
   logic                 policy_ff;
   logic [HIT_CYC_W-1:0] hit_cycles_ff;
   logic [PENALTY_W-1:0] penalty_cycles_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff    <= OFFSET_BITS_RST;
         policy_ff         <= POLICY_RST;
         hit_cycles_ff     <= HIT_CYCLES_RST;
         penalty_cycles_ff <= PENALTY_CYCLES_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OFFSET_BITS:    offset_bits_ff    <= csr_data[OFFSET_W-1:0];
            CSR_POLICY:         policy_ff         <= csr_data[0];
            CSR_HIT_CYCLES:     hit_cycles_ff     <= csr_data[HIT_CYC_W-1:0];
            CSR_PENALTY_CYCLES: penalty_cycles_ff <= csr_data[PENALTY_W-1:0];
            default: ;
         endcase
      end
   end

   // control and result registers
   state_type            state_ff, state_in;
   logic [SET_W-1:0]     clr_ff, clr_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [WAY_USED_W-1:0] rsp_way_ff, rsp_way_in;
   logic [LATENCY_W-1:0] rsp_latency_ff, rsp_latency_in;
   logic [COUNT_W-1:0]   access_ff, access_in;
   logic [COUNT_W-1:0]   hits_ff, hits_in;
   logic [COUNT_W-1:0]   misses_ff, misses_in;

   logic [ADDR_W-1:0]       block;
   logic                    take;
   logic                    commit;
   logic                    tag_we, meta_we, rd_en;
   logic [SET_W-1:0]        meta_waddr;
   logic [META_W-1:0]       meta_wdata;
   logic [META_W-1:0]       meta_rdata;
   logic [WAYS*TAG_W-1:0]   tag_rdata;
   logic [WAYS*TAG_W-1:0]   new_tags;
   logic [WAYS-1:0]         new_valid;
   logic [ORDER_W-1:0]      new_order;
   lookup_status_type       status;

   assign block  = req_address >> offset_bits_ff;
   assign take   = req_valid && !req_stall;
   assign commit = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);

   sac_ram #(
      .DEPTH(SETS),
      .WIDTH(WAYS * TAG_W)
   ) u_tag_ram (
      .clock(clock),
      .we   (tag_we),
      .waddr(set_ff),
      .wdata(new_tags),
      .re   (rd_en),
      .raddr(set_in),
      .rdata(tag_rdata)
   );

   sac_ram #(
      .DEPTH(SETS),
      .WIDTH(META_W)
   ) u_meta_ram (
      .clock(clock),
      .we   (meta_we),
      .waddr(meta_waddr),
      .wdata(meta_wdata),
      .re   (rd_en),
      .raddr(set_in),
      .rdata(meta_rdata)
   );

   sac_way_logic #(
      .WAYS (WAYS),
      .TAG_W(TAG_W)
   ) u_way_logic (
      .tag       (tag_ff),
      .line_tags (tag_rdata),
      .line_valid(meta_rdata[WAYS-1:0]),
      .way_order (meta_rdata[META_W-1:WAYS]),
      .policy    (policy_ff),
      .status    (status),
      .new_tags  (new_tags),
      .new_valid (new_valid),
      .new_order (new_order)
   );

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_way_in     = rsp_way_ff;
      rsp_latency_in = rsp_latency_ff;
      access_in      = access_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      rd_en          = 1'b0;
      tag_we         = 1'b0;
      meta_we        = 1'b0;
      meta_waddr     = set_ff;
      meta_wdata     = {new_order, new_valid};

      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = {init_order(), {WAYS{1'b0}}};
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == SET_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               rd_en    = 1'b1;
               set_in   = block[SET_W-1:0] & SET_MASK;
               tag_in   = TAG_W'(block >> SET_BITS);
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (commit) begin
               tag_we         = !status.hit;
               meta_we        = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = status.hit;
               rsp_way_in     = status.way[WAY_USED_W-1:0];
               rsp_latency_in = LATENCY_W'(hit_cycles_ff) +
                                (status.hit ? '0 : LATENCY_W'(penalty_cycles_ff));
               access_in      = sat_inc(access_ff);
               hits_in        = status.hit ? sat_inc(hits_ff) : hits_ff;
               misses_in      = status.hit ? misses_ff : sat_inc(misses_ff);
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         access_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         access_ff    <= access_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
      end
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_way_ff     <= rsp_way_in;
      rsp_latency_ff <= rsp_latency_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_way_used     = rsp_way_ff;
   assign rsp_latency      = rsp_latency_ff;
   assign rsp_access_total = access_ff;
   assign rsp_hit_total    = hits_ff;
   assign rsp_miss_total   = misses_ff;

   // no address transfer while the memories are being initialized
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("address transfer during clearing pass");

   a_take_then_lookup: assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == ST_LOOKUP))
      else $error("accepted address did not enter lookup");

   a_counts_agree: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (access_ff != '1)) |->
      ((COUNT_W + 1)'(access_ff) == (COUNT_W + 1)'(hits_ff) + (COUNT_W + 1)'(misses_ff)))
      else $error("access count differs from hits plus misses");

   a_hit_latency: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_latency_ff == LATENCY_W'(hit_cycles_ff)))
      else $error("hit latency mismatch");

   a_tag_write_on_miss: assert property (@(posedge clock) disable iff (reset)
      tag_we |=> (rsp_valid_ff && !rsp_hit_ff))
      else $error("tag row written without a miss result");

endmodule
